@@ src/grip_vote_and_velocity_macros.svh @@
// assertion macros for the grip vote and velocity block
`ifndef GRIP_VOTE_AND_VELOCITY_MACROS_SVH
`define GRIP_VOTE_AND_VELOCITY_MACROS_SVH

// property that must hold at every clock edge out of reset
`define GVV_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// implication checked at every clock edge out of reset
`define GVV_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ src/gvv_pkg.sv @@
// types, constants and control store of the grip vote and velocity block
`timescale 1ns / 1ps
`default_nettype none

package gvv_pkg;

    localparam int unsigned CLS_W    = 3;
    localparam int unsigned MAV_W    = 24;
    localparam int unsigned VEL_W    = 17;
    localparam int unsigned DIV_STEPS = 16;
    localparam int unsigned DIV_CNT_W = 4;

    localparam logic [VEL_W-1:0] FULL_SPEED = 17'h10000;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_WINDOW = 1'b1;

    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_NIL   = 2'd0;
    localparam t_cfg_idx CFG_OPEN  = 2'd1;
    localparam t_cfg_idx CFG_POWER = 2'd2;

    typedef struct packed {
        logic             op;
        logic             window_active;
        logic [CLS_W-1:0] class_index;
        logic [MAV_W-1:0] sum_mav;
        logic [MAV_W-1:0] low_threshold;
        logic [MAV_W-1:0] high_threshold;
    } t_in_item;

    typedef struct packed {
        logic [CLS_W-1:0] grip_class;
        logic [VEL_W-1:0] grip_velocity;
    } t_out_item;

    // step counter and its named steps
    typedef logic [3:0] t_pc;
    localparam t_pc ST_WAIT   = 4'd0;
    localparam t_pc ST_DECODE = 4'd1;
    localparam t_pc ST_VSETUP = 4'd2;
    localparam t_pc ST_VCHECK = 4'd3;
    localparam t_pc ST_DIV    = 4'd4;
    localparam t_pc ST_PUSH   = 4'd5;
    localparam t_pc ST_CLEAR  = 4'd6;
    localparam t_pc ST_TALLY  = 4'd7;
    localparam t_pc ST_MAXI   = 4'd8;
    localparam t_pc ST_MAX    = 4'd9;
    localparam t_pc ST_GRIP   = 4'd10;
    localparam t_pc ST_EMIT   = 4'd11;
    localparam t_pc ST_LAST   = ST_EMIT;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_CAPTURE,
        DP_LOAD_TABLE,
        DP_VEL_SETUP,
        DP_DIV_STEP,
        DP_PUSH,
        DP_CLEAR_TALLY,
        DP_TALLY,
        DP_MAX_INIT,
        DP_MAX_STEP,
        DP_GRIP,
        DP_EMIT
    } t_dp_op;

    typedef enum logic [3:0] {
        JC_NONE,
        JC_ALWAYS,
        JC_NO_INPUT,
        JC_IS_LOAD,
        JC_INACTIVE,
        JC_NO_DIV,
        JC_DIV_MORE,
        JC_SCAN_MORE,
        JC_MAX_MORE,
        JC_OUT_BUSY
    } t_jc;

    typedef struct packed {
        t_dp_op op;
        t_jc    cond;
        t_pc    target;
    } t_uword;

    typedef struct packed {
        logic in_valid;
        logic is_load;
        logic inactive;
        logic no_div;
        logic div_more;
        logic scan_more;
        logic max_more;
        logic out_busy;
    } t_flags;

    // microprogram: taken jump goes to target, otherwise the next step
    function automatic t_uword ucode_rom(input t_pc pc);
        t_uword w;
        unique case (pc)
            ST_WAIT:   w = '{op: DP_CAPTURE,     cond: JC_NO_INPUT,  target: ST_WAIT};
            ST_DECODE: w = '{op: DP_LOAD_TABLE,  cond: JC_IS_LOAD,   target: ST_EMIT};
            ST_VSETUP: w = '{op: DP_VEL_SETUP,   cond: JC_INACTIVE,  target: ST_CLEAR};
            ST_VCHECK: w = '{op: DP_NOP,         cond: JC_NO_DIV,    target: ST_PUSH};
            ST_DIV:    w = '{op: DP_DIV_STEP,    cond: JC_DIV_MORE,  target: ST_DIV};
            ST_PUSH:   w = '{op: DP_PUSH,        cond: JC_NONE,      target: ST_WAIT};
            ST_CLEAR:  w = '{op: DP_CLEAR_TALLY, cond: JC_NONE,      target: ST_WAIT};
            ST_TALLY:  w = '{op: DP_TALLY,       cond: JC_SCAN_MORE, target: ST_TALLY};
            ST_MAXI:   w = '{op: DP_MAX_INIT,    cond: JC_NONE,      target: ST_WAIT};
            ST_MAX:    w = '{op: DP_MAX_STEP,    cond: JC_MAX_MORE,  target: ST_MAX};
            ST_GRIP:   w = '{op: DP_GRIP,        cond: JC_NONE,      target: ST_WAIT};
            ST_EMIT:   w = '{op: DP_EMIT,        cond: JC_OUT_BUSY,  target: ST_EMIT};
            default:   w = '{op: DP_NOP,         cond: JC_ALWAYS,    target: ST_WAIT};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

@@ src/gvv_stream_if.sv @@
// valid/ready channel carrying one item
`timescale 1ns / 1ps
`default_nettype none

interface gvv_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ src/gvv_ram.sv @@
// generic single write, single read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module gvv_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 8,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ src/gvv_sequencer.sv @@
// step counter and control store of the microcoded sequencer
`timescale 1ns / 1ps
`default_nettype none

module gvv_sequencer (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire gvv_pkg::t_flags i_flags,
    output gvv_pkg::t_uword      o_uword
);
    import gvv_pkg::*;

    t_pc    r_pc;
    t_pc    n_pc;
    t_uword uw;
    logic   take;

    always_comb begin
        uw = ucode_rom(r_pc);
    end

    always_comb begin
        unique case (uw.cond)
            JC_NONE:      take = 1'b0;
            JC_ALWAYS:    take = 1'b1;
            JC_NO_INPUT:  take = !i_flags.in_valid;
            JC_IS_LOAD:   take = i_flags.is_load;
            JC_INACTIVE:  take = i_flags.inactive;
            JC_NO_DIV:    take = i_flags.no_div;
            JC_DIV_MORE:  take = i_flags.div_more;
            JC_SCAN_MORE: take = i_flags.scan_more;
            JC_MAX_MORE:  take = i_flags.max_more;
            JC_OUT_BUSY:  take = i_flags.out_busy;
            default:      take = 1'b0;
        endcase
    end

    always_comb begin
        if (take) begin
            n_pc = uw.target;
        end else if (r_pc == ST_LAST) begin
            n_pc = ST_WAIT;
        end else begin
            n_pc = r_pc + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= ST_WAIT;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_uword = uw;

endmodule

`default_nettype wire

@@ src/grip_vote_and_velocity.sv @@
// grip vote and velocity: top level with datapath, history ring and sequencer
//   i_item is a valid/ready input channel; op 0 loads the low and high
//   thresholds of one class, op 1 is one classified window
//   o_result is a valid/ready output channel; every item gives exactly one
//   result item (grip class clamped at the power class, held velocity q1.16)
//   i_cfg_we/i_cfg_index/i_cfg_data write nil, open and power class codes;
//   the user must write them only while the block is idle, and the block
//   itself does not enforce it
// the sequencer returns to its wait step as the result is registered and takes
// the next item only there, so no item is taken while another is in flight
// the velocity comes from a 16 step restoring divider; the ring count (one ram
// entry a cycle) and the class scan (one tally a cycle) form the vote
// reset: thresholds zero, history all class 0 (valid bits cleared), grips at
// class 0, velocity zero; no clearing pass is needed
// a stalled receiver holds the result in the output register; the sequencer
// waits in its emit step until the register frees, and takes no new item
`timescale 1ns / 1ps
`default_nettype none
`include "grip_vote_and_velocity_macros.svh"

module grip_vote_and_velocity #(
    parameter int unsigned HISTORY_DEPTH = 8,
    parameter int unsigned CLASS_COUNT   = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    gvv_stream_if.sink             i_item,
    gvv_stream_if.source           o_result,
    input  wire logic              i_cfg_we,
    input  wire gvv_pkg::t_cfg_idx i_cfg_index,
    input  wire logic [2:0]        i_cfg_data
);
    import gvv_pkg::*;

    localparam int unsigned SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int unsigned IDX_W  = $clog2(HISTORY_DEPTH + 1);
    localparam int unsigned CIDX_W = $clog2(CLASS_COUNT);

    // configuration registers
    logic [CLS_W-1:0] r_nil;
    logic [CLS_W-1:0] r_open;
    logic [CLS_W-1:0] r_power;

    // captured item
    logic             r_op;
    logic             r_active;
    logic [CLS_W-1:0] r_cls;
    logic [MAV_W-1:0] r_sum;
    logic [MAV_W-1:0] r_lo_in;
    logic [MAV_W-1:0] r_hi_in;

    // threshold tables and grip state
    logic [MAV_W-1:0] r_low_tab  [CLASS_COUNT];
    logic [MAV_W-1:0] r_high_tab [CLASS_COUNT];
    logic [CLS_W-1:0] r_last;
    logic [CLS_W-1:0] r_cur;
    logic [VEL_W-1:0] r_held;

    // velocity and divider
    logic [VEL_W-1:0]     r_vel;
    logic [MAV_W-1:0]     r_rem;
    logic [MAV_W-1:0]     r_den;
    logic                 r_div_needed;
    logic [DIV_CNT_W-1:0] r_div_cnt;

    // history ring
    logic [HISTORY_DEPTH-1:0] r_hist_vld;
    logic [SLOT_W-1:0]        r_slot;
    logic [IDX_W-1:0]         r_idx;
    logic                     r_rd_vld;
    logic [SLOT_W-1:0]        ram_raddr;
    logic [CLS_W-1:0]         ram_rdata;

    // vote
    logic [IDX_W-1:0]  r_tally [CLASS_COUNT];
    logic [CIDX_W-1:0] r_k;
    logic [CIDX_W-1:0] r_best;
    logic [IDX_W-1:0]  r_best_cnt;

    // output register
    logic             r_out_valid;
    logic [CLS_W-1:0] r_out_grip;
    logic [VEL_W-1:0] r_out_vel;

    t_uword uw;
    t_flags flags;

    // combinational datapath nets
    logic              cls_ok;
    logic [CIDX_W-1:0] tab_idx;
    logic [MAV_W-1:0]  vs_lo;
    logic [MAV_W-1:0]  vs_hi;
    logic [VEL_W-1:0]  vs_vel;
    logic              vs_need;
    logic [MAV_W:0]    dv_shift;
    logic              dv_ge;
    logic [MAV_W:0]    dv_diff;
    logic [CLS_W-1:0]  hist_cls;
    logic              hist_ok;
    logic [CIDX_W-1:0] tally_addr;
    logic [IDX_W-1:0]  tally_rd;
    logic [CLS_W-1:0]  vote;
    logic              grip_take;
    logic [CLS_W-1:0]  clamped;
    logic [SLOT_W-1:0] slot_next;

    gvv_sequencer u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_uword (uw)
    );

    gvv_ram #(
        .WIDTH (CLS_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (uw.op == DP_PUSH),
        .i_waddr (r_slot),
        .i_wdata (r_cls),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // condition flags for the sequencer
    always_comb begin
        flags.in_valid  = i_item.valid;
        flags.is_load   = (r_op == OP_LOAD);
        flags.inactive  = !r_active;
        flags.no_div    = !r_div_needed;
        flags.div_more  = (r_div_cnt != DIV_CNT_W'(DIV_STEPS - 1));
        flags.scan_more = (r_idx != IDX_W'(HISTORY_DEPTH));
        flags.max_more  = (r_k != CIDX_W'(CLASS_COUNT - 1));
        flags.out_busy  = r_out_valid && !o_result.ready;
    end

    assign i_item.ready = (uw.op == DP_CAPTURE);

    // threshold lookup and velocity case split
    always_comb begin
        cls_ok  = (32'(r_cls) < CLASS_COUNT);
        tab_idx = CIDX_W'(r_cls);
        vs_lo   = cls_ok ? r_low_tab[tab_idx]  : '0;
        vs_hi   = cls_ok ? r_high_tab[tab_idx] : '0;
        vs_vel  = '0;
        vs_need = 1'b0;
        if (r_active) begin
            if (vs_hi <= vs_lo) begin
                // thresholds not ordered: all or nothing
                vs_vel = (r_sum > vs_lo) ? FULL_SPEED : '0;
            end else if (r_sum <= vs_lo) begin
                vs_vel = '0;
            end else if (r_sum >= vs_hi) begin
                vs_vel = FULL_SPEED;
            end else begin
                vs_need = 1'b1;
            end
        end
    end

    // one restoring divide step
    always_comb begin
        dv_shift = {r_rem, 1'b0};
        dv_ge    = (dv_shift >= {1'b0, r_den});
        dv_diff  = dv_shift - {1'b0, r_den};
    end

    // ring read side; never-written entries read as class 0
    always_comb begin
        if (uw.op == DP_CLEAR_TALLY) begin
            ram_raddr = '0;
        end else if (32'(r_idx) < HISTORY_DEPTH) begin
            ram_raddr = SLOT_W'(r_idx);
        end else begin
            ram_raddr = '0;
        end
        hist_cls   = r_rd_vld ? ram_rdata : '0;
        hist_ok    = (32'(hist_cls) < CLASS_COUNT);
        tally_addr = (uw.op == DP_TALLY) ? CIDX_W'(hist_cls) : r_k;
        tally_rd   = r_tally[tally_addr];
    end

    // grip rule and power clamp
    always_comb begin
        vote      = CLS_W'(r_best);
        grip_take = (r_last == r_open) || (vote == r_open) ||
                    (vote == r_nil) || (vote == r_last);
        clamped   = (r_cur >= r_power) ? r_power : r_cur;
        slot_next = (r_slot == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : r_slot + SLOT_W'(1);
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nil   <= 3'd0;
            r_open  <= 3'd1;
            r_power <= 3'd2;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_NIL:   r_nil   <= i_cfg_data;
                CFG_OPEN:  r_open  <= i_cfg_data;
                CFG_POWER: r_power <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // state with a defined reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CLASS_COUNT; i++) begin
                r_low_tab[i]  <= '0;
                r_high_tab[i] <= '0;
            end
            r_hist_vld  <= '0;
            r_slot      <= '0;
            r_last      <= '0;
            r_cur       <= '0;
            r_held      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // a new result may replace one taken at this edge
            if (uw.op == DP_EMIT && !flags.out_busy) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (uw.op)
                DP_LOAD_TABLE: begin
                    if (r_op == OP_LOAD && cls_ok) begin
                        r_low_tab[tab_idx]  <= r_lo_in;
                        r_high_tab[tab_idx] <= r_hi_in;
                    end
                end
                DP_PUSH: begin
                    r_hist_vld[r_slot] <= 1'b1;
                    r_slot             <= slot_next;
                end
                DP_GRIP: begin
                    if (grip_take) begin
                        r_cur  <= vote;
                        r_held <= r_vel;
                        if (vote != r_nil) begin
                            r_last <= vote;
                        end
                    end
                end
                DP_EMIT: begin
                    if (!flags.out_busy) begin
                        r_cur <= clamped;
                    end
                end
                default: ;
            endcase
        end
    end

    // working registers, always written before they are read
    always_ff @(posedge i_clk) begin
        r_rd_vld <= r_hist_vld[ram_raddr];
        unique case (uw.op)
            DP_CAPTURE: begin
                if (i_item.valid) begin
                    r_op     <= i_item.payload.op;
                    r_active <= i_item.payload.window_active;
                    r_cls    <= i_item.payload.class_index;
                    r_sum    <= i_item.payload.sum_mav;
                    r_lo_in  <= i_item.payload.low_threshold;
                    r_hi_in  <= i_item.payload.high_threshold;
                end
            end
            DP_VEL_SETUP: begin
                r_vel        <= vs_vel;
                r_div_needed <= vs_need;
                r_rem        <= r_sum - vs_lo;
                r_den        <= vs_hi - vs_lo;
                r_div_cnt    <= '0;
            end
            DP_DIV_STEP: begin
                r_rem     <= dv_ge ? dv_diff[MAV_W-1:0] : dv_shift[MAV_W-1:0];
                r_vel     <= {r_vel[VEL_W-2:0], dv_ge};
                r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
            end
            DP_CLEAR_TALLY: begin
                for (int i = 0; i < CLASS_COUNT; i++) begin
                    r_tally[i] <= '0;
                end
                r_k   <= '0;
                r_idx <= IDX_W'(1);
            end
            DP_TALLY: begin
                if (hist_ok) begin
                    r_tally[tally_addr] <= tally_rd + IDX_W'(1);
                end
                if (flags.scan_more) begin
                    r_idx <= r_idx + IDX_W'(1);
                end
            end
            DP_MAX_INIT: begin
                r_best     <= '0;
                r_best_cnt <= tally_rd;
                r_k        <= CIDX_W'(1);
            end
            DP_MAX_STEP: begin
                // strict compare keeps the lowest class on a tie
                if (tally_rd > r_best_cnt) begin
                    r_best     <= r_k;
                    r_best_cnt <= tally_rd;
                end
                r_k <= r_k + CIDX_W'(1);
            end
            DP_EMIT: begin
                if (!flags.out_busy) begin
                    r_out_grip <= clamped;
                    r_out_vel  <= r_held;
                end
            end
            default: ;
        endcase
    end

    assign o_result.valid                 = r_out_valid;
    assign o_result.payload.grip_class    = r_out_grip;
    assign o_result.payload.grip_velocity = r_out_vel;

    `GVV_ASSERT_ALWAYS(a_slot_range, 32'(r_slot) < HISTORY_DEPTH, "history slot out of range")
    `GVV_ASSERT_ALWAYS(a_vel_bound, r_held <= FULL_SPEED, "held velocity above full speed")
    `GVV_ASSERT_IMPLY(a_out_from_emit, r_out_valid && !$past(r_out_valid), $past(uw.op == DP_EMIT), "result loaded outside emit step")

endmodule

`default_nettype wire

@@ bench/tb.sv @@
// self-checking bench for the grip vote and velocity block: directed table then random items
`timescale 1ns / 1ps

module tb;
    import gvv_pkg::*;

    localparam int unsigned CLASS_N         = 8;
    localparam int unsigned RING_N          = 8;
    localparam int unsigned PHASES          = 8;
    localparam int unsigned ITEMS_PER_PHASE = 141;
    localparam int unsigned LONG_HOLD       = 400;
    localparam int unsigned SETTLE_CYCLES   = 5;
    localparam int unsigned TAIL_CYCLES     = 50;
    localparam int unsigned CYCLE_LIMIT     = 1000000;
    localparam int unsigned REPORT_CAP      = 10;

    // one row of the directed table: the item, and a hand-written result where it is obvious
    typedef struct packed {
        t_in_item  item;
        logic      typed;
        t_out_item want;
    } t_row;

    // columns: op, active, class, sum, low, high | typed | grip, velocity
    localparam t_row DIRECTED_ROWS [25] = '{
        // inactive window straight after reset: nil grip, zero speed
        '{'{OP_WINDOW, 1'b0, 3'd5, 24'hFFFFFF, 24'd0, 24'd0},     1'b1, '{3'd0, 17'd0}},
        // threshold loads leave the result untouched
        '{'{OP_LOAD,   1'b1, 3'd7, 24'hFFFFFF, 24'd0, 24'hFFFFFF}, 1'b1, '{3'd0, 17'd0}},
        '{'{OP_LOAD,   1'b0, 3'd1, 24'd0, 24'hFFFFFF, 24'd0},      1'b1, '{3'd0, 17'd0}},
        '{'{OP_LOAD,   1'b1, 3'd2, 24'd0, 24'd1000, 24'd1000},     1'b1, '{3'd0, 17'd0}},
        '{'{OP_LOAD,   1'b0, 3'd3, 24'd0, 24'd100, 24'd1100},      1'b1, '{3'd0, 17'd0}},
        // full range thresholds: top of the sum saturates, bottom gives zero
        '{'{OP_WINDOW, 1'b1, 3'd7, 24'hFFFFFF, 24'd0, 24'd0},     1'b1, '{3'd0, FULL_SPEED}},
        '{'{OP_WINDOW, 1'b1, 3'd7, 24'd0, 24'd0, 24'd0},          1'b1, '{3'd0, 17'd0}},
        // reversed thresholds, sum equal to low: no speed
        '{'{OP_WINDOW, 1'b1, 3'd1, 24'hFFFFFF, 24'd0, 24'd0},     1'b1, '{3'd0, 17'd0}},
        // class 3 fills the ring; the vote for 3 is refused while the last grip is nil
        '{'{OP_WINDOW, 1'b1, 3'd3, 24'd100, 24'd0, 24'd0},        1'b0, '0},
        '{'{OP_WINDOW, 1'b1, 3'd3, 24'd600, 24'd0, 24'd0},        1'b0, '0},
        '{'{OP_WINDOW, 1'b1, 3'd3, 24'd1100, 24'd0, 24'd0},       1'b0, '0},
        '{'{OP_WINDOW, 1'b1, 3'd3, 24'd101, 24'd0, 24'd0},        1'b0, '0},
        '{'{OP_WINDOW, 1'b1, 3'd3, 24'd1099, 24'd0, 24'd0},       1'b0, '0},
        // equal thresholds: at low gives zero, just above gives full speed
        '{'{OP_WINDOW, 1'b1, 3'd2, 24'd1000, 24'd0, 24'd0},       1'b0, '0},
        '{'{OP_WINDOW, 1'b1, 3'd2, 24'd1001, 24'd0, 24'd0},       1'b0, '0},
        '{'{OP_WINDOW, 1'b0, 3'd0, 24'd0, 24'd0, 24'd0},          1'b0, '0},
        // open hand takes the vote
        '{'{OP_WINDOW, 1'b1, 3'd1, 24'd0, 24'd0, 24'd0},          1'b0, '0},
        '{'{OP_WINDOW, 1'b1, 3'd1, 24'd0, 24'd0, 24'd0},          1'b0, '0},
        '{'{OP_WINDOW, 1'b1, 3'd1, 24'd0, 24'd0, 24'd0},          1'b0, '0},
        '{'{OP_WINDOW, 1'b1, 3'd1, 24'd0, 24'd0, 24'd0},          1'b0, '0},
        // class 3 catches up: tie goes to open, then 3 wins and clamps at power
        '{'{OP_WINDOW, 1'b1, 3'd3, 24'd700, 24'd0, 24'd0},        1'b0, '0},
        '{'{OP_WINDOW, 1'b1, 3'd3, 24'd700, 24'd0, 24'd0},        1'b0, '0},
        '{'{OP_WINDOW, 1'b1, 3'd3, 24'd700, 24'd0, 24'd0},        1'b0, '0},
        '{'{OP_WINDOW, 1'b1, 3'd3, 24'd700, 24'd0, 24'd0},        1'b0, '0},
        '{'{OP_WINDOW, 1'b1, 3'd3, 24'd900, 24'd0, 24'd0},        1'b0, '0}
    };

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    t_cfg_idx             i_cfg_index;
    logic [2:0]           i_cfg_data;

    gvv_stream_if #(.t_payload(t_in_item))  item_ch ();
    gvv_stream_if #(.t_payload(t_out_item)) result_ch ();

    grip_vote_and_velocity i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (item_ch),
        .o_result    (result_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // predictor state: threshold tables, class ring, grips and the held speed
    logic [MAV_W-1:0] thr_low  [CLASS_N];
    logic [MAV_W-1:0] thr_high [CLASS_N];
    logic [CLS_W-1:0] vote_ring [RING_N];
    int unsigned      ring_slot;
    logic [CLS_W-1:0] last_grip;
    logic [CLS_W-1:0] cur_grip;
    logic [VEL_W-1:0] held_vel;
    logic [2:0]       cfg_nil;
    logic [2:0]       cfg_open;
    logic [2:0]       cfg_power;

    t_out_item   grip_expected [$];
    int unsigned mismatches  = 0;
    int unsigned cycle_count = 0;

    // random item shaping: a gesture class held for a burst of windows
    logic [CLS_W-1:0] gesture      = '0;
    int unsigned      gesture_left = 0;

    // idling switches and the request for one long hold-off on the result side
    bit          tx_idle  = 1'b1;
    bit          rx_idle  = 1'b1;
    int unsigned hold_req = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // proportional speed in q1.16 from the summed mav and the class thresholds
    function automatic logic [VEL_W-1:0] speed_of(input logic [MAV_W-1:0] sum,
                                                  input logic [MAV_W-1:0] lo,
                                                  input logic [MAV_W-1:0] hi);
        logic [MAV_W+15:0] num;
        if (hi <= lo)
            return (sum > lo) ? FULL_SPEED : '0;
        if (sum <= lo)
            return '0;
        if (sum >= hi)
            return FULL_SPEED;
        num = {sum - lo, 16'h0000};
        return VEL_W'(num / (hi - lo));
    endfunction

    // one item through the predictor: returns the grip and speed it should report
    function automatic t_out_item predict_grip(input t_in_item it);
        logic [VEL_W-1:0] vel;
        logic [CLS_W-1:0] vote;
        int unsigned      tally [CLASS_N];
        int unsigned      best_n;
        t_out_item        res;
        vel = '0;
        if (it.op == OP_LOAD) begin
            thr_low[it.class_index]  = it.low_threshold;
            thr_high[it.class_index] = it.high_threshold;
        end else begin
            // an inactive window keeps the ring but still votes
            if (it.window_active) begin
                vel = speed_of(it.sum_mav, thr_low[it.class_index], thr_high[it.class_index]);
                vote_ring[ring_slot] = it.class_index;
                ring_slot = (ring_slot == RING_N - 1) ? 0 : ring_slot + 1;
            end
            foreach (tally[k])
                tally[k] = 0;
            foreach (vote_ring[k])
                tally[vote_ring[k]]++;
            // strict compare so a tie keeps the lowest class
            vote   = '0;
            best_n = tally[0];
            for (int k = 1; k < CLASS_N; k++) begin
                if (tally[k] > best_n) begin
                    vote   = CLS_W'(k);
                    best_n = tally[k];
                end
            end
            if (last_grip == cfg_open || vote == cfg_open || vote == cfg_nil ||
                vote == last_grip) begin
                cur_grip = vote;
                if (vote != cfg_nil)
                    last_grip = vote;
                held_vel = vel;
            end
        end
        // clamped grip is written back
        if (cur_grip >= cfg_power)
            cur_grip = cfg_power;
        res.grip_class    = cur_grip;
        res.grip_velocity = held_vel;
        return res;
    endfunction

    // mostly no gap, some short, a few long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 50);
    endfunction

    // random item: mostly windows in bursts of one gesture, sums placed around the thresholds
    function automatic t_in_item make_item();
        t_in_item         it;
        int unsigned      r;
        logic [MAV_W-1:0] lo;
        logic [MAV_W-1:0] hi;
        it.op             = OP_WINDOW;
        it.window_active  = 1'b1;
        it.class_index    = CLS_W'($urandom_range(0, CLASS_N - 1));
        it.sum_mav        = MAV_W'($urandom);
        it.low_threshold  = MAV_W'($urandom);
        it.high_threshold = MAV_W'($urandom);
        lo = it.low_threshold;
        hi = it.high_threshold;
        if (gesture_left == 0) begin
            gesture      = CLS_W'($urandom_range(0, CLASS_N - 1));
            gesture_left = $urandom_range(2, 12);
        end
        r = $urandom_range(0, 99);
        if (r < 12) begin
            it.op = OP_LOAD;
            r = $urandom_range(0, 99);
            if (r < 55) begin
                // ordered thresholds, small scale
                lo = MAV_W'($urandom_range(0, 5000));
                hi = lo + MAV_W'($urandom_range(1, 300000));
            end else if (r < 85 && r >= 75) begin
                hi = lo;
            end else if (r < 95 && r >= 85) begin
                // reversed thresholds
                lo = MAV_W'($urandom_range(2000, 24'hFFFFFF));
                hi = MAV_W'($urandom_range(0, lo - 1));
            end else if (r >= 95) begin
                lo = $urandom_range(0, 1) ? 24'hFFFFFF : 24'd0;
                hi = ~lo;
            end
            it.low_threshold  = lo;
            it.high_threshold = hi;
        end else begin
            it.window_active = (r >= 22);
            if ($urandom_range(0, 99) < 75)
                it.class_index = gesture;
            gesture_left--;
            lo = thr_low[it.class_index];
            hi = thr_high[it.class_index];
            r  = $urandom_range(0, 99);
            if (r < 10)
                it.sum_mav = '0;
            else if (r < 20)
                it.sum_mav = 24'hFFFFFF;
            else if (r < 30)
                it.sum_mav = lo;
            else if (r < 40)
                it.sum_mav = hi;
            else if (r < 45)
                it.sum_mav = lo + 1'b1;
            else if (r < 50)
                it.sum_mav = hi - 1'b1;
            else if (r < 80 && hi > lo)
                it.sum_mav = lo + MAV_W'($urandom_range(0, hi - lo));
        end
        return it;
    endfunction

    // offer one item until taken, log its prediction, then maybe leave a gap
    task automatic send_item(input t_in_item it, input logic typed, input t_out_item want);
        t_out_item   pred;
        int unsigned gap;
        item_ch.valid   <= 1'b1;
        item_ch.payload <= it;
        @(posedge i_clk);
        while (!item_ch.ready)
            @(posedge i_clk);
        pred = predict_grip(it);
        grip_expected.push_back(typed ? want : pred);
        if (tx_idle) begin
            gap = pick_gap();
            if (gap != 0) begin
                item_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // stop offering and wait for every outstanding result
    task automatic wait_drained();
        item_ch.valid <= 1'b0;
        do
            @(posedge i_clk);
        while (grip_expected.size() != 0);
    endtask

    // new class codes, written only with the block idle
    task automatic apply_setting(input logic [2:0] nil_c, input logic [2:0] open_c,
                                 input logic [2:0] power_c);
        wait_drained();
        // let the sequencer get back to its wait step
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_NIL;
        i_cfg_data  <= nil_c;
        @(posedge i_clk);
        i_cfg_index <= CFG_OPEN;
        i_cfg_data  <= open_c;
        @(posedge i_clk);
        i_cfg_index <= CFG_POWER;
        i_cfg_data  <= power_c;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_nil   = nil_c;
        cfg_open  = open_c;
        cfg_power = power_c;
    endtask

    task automatic flag_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
        mismatches++;
        if (mismatches <= REPORT_CAP)
            $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, what, want, got);
    endtask

    // result side: random stalls, plus the long hold-off when asked for
    initial begin : result_sink
        int unsigned stall_left;
        stall_left = 0;
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                result_ch.ready <= 1'b0;
            end else if (hold_req != 0) begin
                stall_left = hold_req;
                hold_req   = 0;
                result_ch.ready <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end else begin
                result_ch.ready <= 1'b1;
                if (rx_idle && $urandom_range(0, 99) < 30)
                    stall_left = pick_gap();
            end
        end
    end

    // every taken result against the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_out_item got;
        t_out_item want;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            got = result_ch.payload;
            if (grip_expected.size() == 0) begin
                flag_mismatch("unexpected result, grip", 0, got.grip_class);
            end else begin
                want = grip_expected.pop_front();
                if (got.grip_class != want.grip_class)
                    flag_mismatch("grip class", want.grip_class, got.grip_class);
                if (got.grip_velocity != want.grip_velocity)
                    flag_mismatch("grip velocity", want.grip_velocity, got.grip_velocity);
            end
        end
    end

    initial begin : stimulus
        int unsigned ph;
        int unsigned n;
        logic [2:0]  s_nil;
        logic [2:0]  s_open;
        logic [2:0]  s_power;

        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_index     <= CFG_NIL;
        i_cfg_data      <= '0;
        item_ch.valid   <= 1'b0;
        item_ch.payload <= '0;

        // predictor mirrors the reset state
        foreach (thr_low[k]) begin
            thr_low[k]  = '0;
            thr_high[k] = '0;
        end
        foreach (vote_ring[k])
            vote_ring[k] = '0;
        ring_slot = 0;
        last_grip = '0;
        cur_grip  = '0;
        held_vel  = '0;
        cfg_nil   = 3'd0;
        cfg_open  = 3'd1;
        cfg_power = 3'd2;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table under the reset codes
        foreach (DIRECTED_ROWS[k])
            send_item(DIRECTED_ROWS[k].item, DIRECTED_ROWS[k].typed, DIRECTED_ROWS[k].want);

        // random phases, each under its own class codes
        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin s_nil = 3'd0; s_open = 3'd1; s_power = 3'd2; end
                1: begin s_nil = 3'd7; s_open = 3'd7; s_power = 3'd7; end
                2: begin s_nil = 3'd0; s_open = 3'd0; s_power = 3'd0; end
                3: begin s_nil = 3'd3; s_open = 3'd5; s_power = 3'd7; end
                4: begin s_nil = 3'd2; s_open = 3'd1; s_power = 3'd0; end
                5: begin s_nil = 3'd6; s_open = 3'd0; s_power = 3'd4; end
                default: begin
                    s_nil   = 3'($urandom_range(0, 7));
                    s_open  = 3'($urandom_range(0, 7));
                    s_power = 3'($urandom_range(0, 7));
                end
            endcase
            apply_setting(s_nil, s_open, s_power);
            // some phases run back to back on one side or the other
            tx_idle = (ph != 3 && ph != 6);
            rx_idle = (ph != 3 && ph != 5);
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                // result side holds off while items keep coming, so the input backs up
                if (ph == 1 && n == 40)
                    hold_req = LONG_HOLD;
                // sender waits for the block to empty
                if (ph == 2 && n == 70)
                    wait_drained();
                send_item(make_item(), 1'b0, '0);
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
